FILE: hw/rtl/lds_pkg.sv
// Package for the longest decreasing subsequence block: sizes, types, state codes.
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

    // Table depth and sample width
    localparam int MAX_LEN    = 1024;
    localparam int DATA_WIDTH = 16;

    // Table address width and length width (length can reach MAX_LEN itself)
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    // Width of the reported length field
    localparam int OUT_LEN_W = 11;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [LEN_W-1:0]             len_t;
    typedef logic [ADDR_W-1:0]            addr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/longest_decreasing_subsequence.sv
// Longest strictly decreasing subsequence over a stream of signed samples.
//
// Input channel (in_valid / in_ready): one word per sample, sample_value plus
// end_of_sequence marking the last sample of a sequence. Output channel
// (out_valid / out_ready): one word per sequence, lds_length and
// length_saturated, issued after the sample carrying end_of_sequence.
//
// Each sample binary-searches a 1024-entry tail memory for the first entry
// not greater than the sample, then overwrites or appends it. The search is
// one memory read per step, with the compare and the next address in the same
// cycle. A sample is taken in IDLE, searched in SEARCH unless the table is
// empty, and written or dropped in UPDATE.
//
// Only one sample is in work at a time. The result sits in an output
// register; while it waits, the block keeps taking samples and only holds an
// end-of-sequence sample until the receiver takes the previous result.
// Reset clears the length, the overflow flag and out_valid; the memory needs
// no clearing because only entries written in the current sequence are read.
`timescale 1ns / 1ps
`default_nettype none

module longest_decreasing_subsequence (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lds_pkg::DATA_WIDTH-1:0] sample_value,
    input  wire logic                           end_of_sequence,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lds_pkg::OUT_LEN_W-1:0]       lds_length,
    output logic                                length_saturated
);

    // Control state
    lds_pkg::state_t state_reg, state_next;
    lds_pkg::len_t   lo_reg, lo_next;
    lds_pkg::len_t   hi_reg, hi_next;
    lds_pkg::len_t   mid_reg, mid_next;
    lds_pkg::len_t   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic            eos_reg, eos_next;
    lds_pkg::data_t  val_reg, val_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [lds_pkg::OUT_LEN_W-1:0] out_len_reg, out_len_next;
    logic                          out_sat_reg, out_sat_next;

    // Tail memory
    lds_pkg::data_t tail_mem [lds_pkg::MAX_LEN];
    lds_pkg::data_t rd_data_reg;
    logic           rd_en;
    lds_pkg::addr_t rd_addr;
    logic           wr_en;

    // Search step helpers
    logic                   greater;
    lds_pkg::len_t          step_lo;
    lds_pkg::len_t          step_hi;
    logic [lds_pkg::LEN_W:0] mid_sum;
    lds_pkg::len_t          step_mid;
    logic                   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign greater   = $signed(rd_data_reg) > $signed(val_reg);
    assign step_lo   = greater ? lds_pkg::len_t'(mid_reg + 1'b1) : lo_reg;
    assign step_hi   = greater ? hi_reg : mid_reg;
    assign mid_sum   = {1'b0, step_lo} + {1'b0, step_hi};
    assign step_mid  = mid_sum[lds_pkg::LEN_W:1];

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        eos_next       = eos_reg;
        val_next       = val_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_len_next   = out_len_reg;
        out_sat_next   = out_sat_reg;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = mid_reg[lds_pkg::ADDR_W-1:0];
        wr_en          = 1'b0;

        unique case (state_reg)
            lds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next = sample_value;
                    eos_next = end_of_sequence;
                    lo_next  = '0;
                    hi_next  = len_reg;
                    mid_next = len_reg >> 1;
                    if (len_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = mid_next[lds_pkg::ADDR_W-1:0];
                        state_next = lds_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = lds_pkg::ST_UPDATE;
                    end
                end
            end

            lds_pkg::ST_SEARCH:
            begin
                // read data of mid_reg is here: narrow the range, fetch next mid
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_mid;
                if (step_lo < step_hi)
                begin
                    rd_en   = 1'b1;
                    rd_addr = step_mid[lds_pkg::ADDR_W-1:0];
                end
                else
                begin
                    state_next = lds_pkg::ST_UPDATE;
                end
            end

            lds_pkg::ST_UPDATE:
            begin
                // overwrite or append; a full table drops the sample
                if (lo_reg < lds_pkg::len_t'(lds_pkg::MAX_LEN))
                begin
                    wr_en = 1'b1;
                    if (lo_reg >= len_reg)
                    begin
                        len_next = lds_pkg::len_t'(lo_reg + 1'b1);
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (!eos_reg)
                begin
                    state_next = lds_pkg::ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = lds_pkg::OUT_LEN_W'(len_next);
                    out_sat_next   = ovf_next;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = lds_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lds_pkg::ST_EMIT;
                end
            end

            lds_pkg::ST_EMIT:
            begin
                // previous result still held by the receiver
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = lds_pkg::OUT_LEN_W'(len_reg);
                    out_sat_next   = ovf_reg;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = lds_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lds_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lds_pkg::ST_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        eos_reg     <= eos_next;
        val_reg     <= val_next;
        out_len_reg <= out_len_next;
        out_sat_reg <= out_sat_next;
    end

    // Tail memory: write in UPDATE, reads never fall in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tail_mem[lo_reg[lds_pkg::ADDR_W-1:0]] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= tail_mem[rd_addr];
        end
    end

    assign out_valid        = out_valid_reg;
    assign lds_length       = out_len_reg;
    assign length_saturated = out_sat_reg;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= lds_pkg::len_t'(lds_pkg::MAX_LEN))
        else $error("length past table depth");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lds_pkg::ST_SEARCH) |-> (lo_reg < hi_reg) && (mid_reg < hi_reg))
        else $error("search range empty while a read is pending");

    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (lo_reg <= len_reg) && !rd_en)
        else $error("table write past live part or colliding with a read");

    a_sat_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && length_saturated)
            |-> (lds_length == lds_pkg::OUT_LEN_W'(lds_pkg::MAX_LEN)))
        else $error("saturation flagged with a short length");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != lds_pkg::ST_IDLE) && !in_ready)
        else $error("sample accepted without being processed");
`endif

endmodule

`default_nettype wire

FILE: test/longest_decreasing_subsequence_test.sv
// Testbench for the longest decreasing subsequence block: random and directed runs, scoreboard check.
`timescale 1ns / 1ps

module longest_decreasing_subsequence_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct {
        logic [lds_pkg::OUT_LEN_W-1:0] length;
        logic                          saturated;
    } lds_result_t;

    // Tracks the tail table of the running sequence and queues the reported lengths
    class decreasing_run_tracker;
        lds_pkg::data_t tails[lds_pkg::MAX_LEN];
        int             run_len;
        bit             table_overflow;
        lds_result_t    expected_lengths[$];
        int             failures;

        function new();
            run_len = 0;
            table_overflow = 0;
            failures = 0;
        endfunction

        // Accepted sample: binary search for first tail not greater than it
        function void note_sample(lds_pkg::data_t v, logic eos);
            int lo;
            int hi;
            int mid;
            lds_result_t r;
            lo = 0;
            hi = run_len;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tails[mid] > v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < lds_pkg::MAX_LEN)
            begin
                tails[lo] = v;
                if (lo >= run_len)
                    run_len = lo + 1;
            end
            else
                table_overflow = 1;
            if (eos)
            begin
                r.length = run_len[lds_pkg::OUT_LEN_W-1:0];
                r.saturated = table_overflow;
                expected_lengths.insert(expected_lengths.size(), r);
                run_len = 0;
                table_overflow = 0;
            end
        endfunction

        // Accepted result word against the oldest expected length
        function void check_result(logic [lds_pkg::OUT_LEN_W-1:0] length, logic saturated);
            lds_result_t r;
            if (expected_lengths.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: unexpected result length=%0d saturated=%0b",
                             length, saturated);
                return;
            end
            r = expected_lengths.pop_front();
            if (length !== r.length || saturated !== r.saturated)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected length=%0d saturated=%0b, got %0d %0b",
                             r.length, r.saturated, length, saturated);
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [lds_pkg::DATA_WIDTH-1:0] sample_value;
    logic                           end_of_sequence;
    logic                           out_valid;
    logic                           out_ready;
    logic [lds_pkg::OUT_LEN_W-1:0]  lds_length;
    logic                           length_saturated;

    decreasing_run_tracker   board;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      cycle_count;

    longest_decreasing_subsequence DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_value     (sample_value),
        .end_of_sequence  (end_of_sequence),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .lds_length       (lds_length),
        .length_saturated (length_saturated)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_value = '0;
        end_of_sequence = 1'b0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        board = new();
    end

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** longest_decreasing_subsequence: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(lds_length, length_saturated);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One sample word; valid stays up into the next call unless the sender idles
    task automatic send_word(input int v, input logic eos);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= v[lds_pkg::DATA_WIDTH-1:0];
        end_of_sequence <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample(lds_pkg::data_t'(v[lds_pkg::DATA_WIDTH-1:0]), eos);
    endtask

    // Hold the input until every pending length has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_lengths.size() != 0)
            @(posedge clk);
    endtask

    // Fill all MAX_LEN entries with a strictly decreasing run; optionally overflow it
    task automatic send_full_table(input bit overflow_run);
        int v;
        int i;
        v = 32767;
        for (i = 0; i < lds_pkg::MAX_LEN; i++)
        begin
            send_word(v, !overflow_run && i == lds_pkg::MAX_LEN - 1);
            v = v - $urandom_range(63, 1);
        end
        if (overflow_run)
        begin
            // below every tail: dropped, flag set
            send_word(v, 1'b0);
            // mid-range: overwrites an entry, length unchanged
            send_word(0, 1'b0);
            send_word(-32768, 1'b1);
        end
    endtask

    // Random sequences: mostly short, some longer, several value shapes
    task automatic send_random_sequences(input int n_items);
        int sent;
        int seq_len;
        int shape;
        int i;
        int cur;
        sent = 0;
        while (sent < n_items)
        begin
            seq_len = ($urandom_range(9) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 1);
            shape = $urandom_range(3);
            cur = $urandom_range(65535) - 32768;
            for (i = 0; i < seq_len; i++)
            begin
                case (shape)
                    0: cur = $urandom_range(65535) - 32768;
                    1: cur = $urandom_range(8) - 4;
                    default:
                    begin
                        // downward drift with some upward noise
                        cur = cur - $urandom_range(300) + $urandom_range(60);
                        if (cur < -32768)
                            cur = 32767 - $urandom_range(1000);
                        if (cur > 32767)
                            cur = 32767;
                    end
                endcase
                send_word(cur, i == seq_len - 1);
                sent++;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        int phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, single-sample sequence, ties, rising and mixed runs
        send_word(32767, 1'b1);
        send_word(-32768, 1'b1);
        send_word(32767, 1'b0);
        send_word(0, 1'b0);
        send_word(-32768, 1'b1);
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word(5, 1'b1);
        send_word(-32768, 1'b0);
        send_word(0, 1'b0);
        send_word(32767, 1'b1);
        send_word(3, 1'b0);
        send_word(1, 1'b0);
        send_word(2, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b1);
        send_word(21845, 1'b0);
        send_word(-21846, 1'b1);
        send_word(-21846, 1'b0);
        send_word(21845, 1'b1);

        // Table filled, then samples dropped past the full depth
        send_full_table(1'b1);
        // Short sequence over a stale table
        send_word(100, 1'b0);
        send_word(200, 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                end
            endcase
            send_random_sequences(ITEMS_PER_PHASE);
            if (phase == 1)
                wait_results_drained();
        end

        // Drain
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.expected_lengths.size() == 0)
            $display("** longest_decreasing_subsequence: PASSED **");
        else
            $display("** longest_decreasing_subsequence: FAILED **");
        $finish;
    end

endmodule
